// ===== design/jdc_pkg.sv =====
// ----------------------------------------------------------------------------
// jdc_pkg: Julian day to calendar date shared definitions
// Constants of the day-number conversion, the day-offset table and the
// result bundle that leaves the datapath pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package jdc_pkg;

    localparam int DayW   = 23;
    localparam int MonthW = 4;
    localparam int DomW   = 5;
    localparam int YearW  = 15;

    // Input range and calendar switch
    localparam logic [DayW-1:0] DAY_LIMIT       = 23'd5373484;
    localparam logic [DayW-1:0] GREGORIAN_START = 23'd2299161;

    // Century correction: alpha = floor((4*(J - 1867216) - 1) / 146097)
    localparam logic [24:0] ALPHA_BASE_X4 = 25'd7468864;    // 4 * 1867216
    localparam logic [17:0] ALPHA_DIV     = 18'd146097;
    localparam logic [7:0]  ALPHA_RCP     = 8'd229;          // floor(2^25 / 146097)
    localparam int          ALPHA_SHIFT   = 25;

    // Year count: C = floor((100*B - 12210) / 36525)
    localparam logic [10:0] B_OFFSET  = 11'd1524;
    localparam logic [30:0] C_OFFSET  = 31'd12210;
    localparam logic [15:0] C_DIV     = 16'd36525;
    localparam logic [14:0] C_RCP     = 15'd29397;           // floor(2^30 / 36525)
    localparam int          C_SHIFT   = 30;

    localparam logic signed [15:0] YEAR_OFFSET = 16'sd4715;

    // floor(30.6001 * e) for e = 0..15
    localparam logic [8:0] MONTH_OFS [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    typedef struct packed {
        logic              valid;
        logic [MonthW-1:0] month;
        logic [DomW-1:0]   day_of_month;
        logic [YearW-1:0]  year;
        logic              range_error;
    } jdc_res_t;

endpackage

`default_nettype wire

// ===== design/jdc_pipe.sv =====
// ----------------------------------------------------------------------------
// jdc_pipe: eight-stage day number to date datapath
// Divisions by constants run as reciprocal multiply plus one correction
// stage; every stage advances together on adv. The last stage is the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jdc_pipe (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire logic [jdc_pkg::DayW-1:0]    day_number,
    output jdc_pkg::jdc_res_t                res
);

    // valid bits, one per stage
    logic [7:1] v_reg;

    // stage 1
    logic [22:0] j1_reg;
    logic        g1_reg, err1_reg;
    logic [24:0] x1_reg, x1_next;
    logic [7:0]  ae1_reg, ae1_next;
    logic [32:0] p1;
    // stage 2
    logic [22:0] j2_reg;
    logic        g2_reg, err2_reg;
    logic [7:0]  al2_reg, al2_next;
    logic [25:0] p2, r2;
    // stage 3
    logic        err3_reg;
    logic [23:0] b3_reg, b3_next, a3;
    logic [29:0] y3_reg, y3_next;
    logic [30:0] h3;
    // stage 4
    logic        err4_reg;
    logic [23:0] b4_reg;
    logic [29:0] y4_reg;
    logic [14:0] ce4_reg;
    logic [44:0] p4;
    // stage 5
    logic        err5_reg;
    logic [23:0] b5_reg;
    logic [14:0] c5_reg, c5_next;
    logic [30:0] p5, r5;
    // stage 6
    logic        err6_reg;
    logic [8:0]  rem6_reg;
    logic [14:0] c6_reg;
    logic [23:0] d6;
    // stage 7
    logic        err7_reg;
    logic [8:0]  rem7_reg;
    logic [14:0] c7_reg;
    logic [3:0]  e7_reg, e7_next;
    // stage 8
    jdc_pkg::jdc_res_t res_reg, res_next;
    logic [8:0]          dom8;
    logic [3:0]          m8;
    logic signed [15:0]  y8;

    // Stage 1: offset day and first alpha estimate
    always_comb
    begin
        x1_next = '0;
        if (day_number >= jdc_pkg::GREGORIAN_START)
            x1_next = {day_number, 2'b00} - jdc_pkg::ALPHA_BASE_X4 - 25'd1;
        p1       = {8'd0, x1_next} * {25'd0, jdc_pkg::ALPHA_RCP};
        ae1_next = p1[jdc_pkg::ALPHA_SHIFT +: 8];
    end

    // Stage 2: correct alpha by one
    always_comb
    begin
        p2       = {18'd0, ae1_reg} * {8'd0, jdc_pkg::ALPHA_DIV};
        r2       = {1'b0, x1_reg} - p2;
        al2_next = ae1_reg + 8'(r2 >= {8'd0, jdc_pkg::ALPHA_DIV});
    end

    // Stage 3: B and the scaled year numerator
    always_comb
    begin
        a3 = {1'b0, j2_reg};
        if (g2_reg)
            a3 = {1'b0, j2_reg} + 24'd1 + {16'd0, al2_reg} - {18'd0, al2_reg[7:2]};
        b3_next = a3 + {13'd0, jdc_pkg::B_OFFSET};
        h3      = {7'd0, b3_next} * 31'd100 - jdc_pkg::C_OFFSET;
        y3_next = h3[29:0];
    end

    // Stage 4: year count estimate
    assign p4 = {15'd0, y3_reg} * {30'd0, jdc_pkg::C_RCP};

    // Stage 5: correct year count by one
    always_comb
    begin
        p5      = {16'd0, ce4_reg} * {15'd0, jdc_pkg::C_DIV};
        r5      = {1'b0, y4_reg} - p5;
        c5_next = ce4_reg + 15'(r5 >= {15'd0, jdc_pkg::C_DIV});
    end

    // Stage 6: days into the shifted year
    assign d6 = {9'd0, c5_reg} * 24'd365 + {11'd0, c5_reg[14:2]};

    // Stage 7: month index from table thresholds
    always_comb
    begin
        e7_next = '0;
        for (int k = 1; k < 16; k++)
            e7_next = e7_next + 4'(rem6_reg > jdc_pkg::MONTH_OFS[k]);
    end

    // Stage 8: day, month, year, zero on range error
    always_comb
    begin
        dom8 = rem7_reg - jdc_pkg::MONTH_OFS[e7_reg];
        m8   = e7_reg - 4'd1;
        if (m8 > 4'd12)
            m8 = m8 - 4'd12;
        y8 = $signed({1'b0, c7_reg}) - jdc_pkg::YEAR_OFFSET;
        if (m8 > 4'd2)
            y8 = y8 - 16'sd1;
        if (y8 <= 16'sd0)
            y8 = y8 - 16'sd1;
        res_next.valid        = v_reg[7];
        res_next.range_error  = err7_reg;
        res_next.month        = err7_reg ? '0 : m8;
        res_next.day_of_month = err7_reg ? '0 : dom8[4:0];
        res_next.year         = err7_reg ? '0 : y8[14:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[6:1], in_valid};
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= '0;
        else if (adv)
            res_reg <= res_next;
    end

    // Payload, advance on adv
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j1_reg   <= day_number;
            g1_reg   <= day_number >= jdc_pkg::GREGORIAN_START;
            err1_reg <= day_number > jdc_pkg::DAY_LIMIT;
            x1_reg   <= x1_next;
            ae1_reg  <= ae1_next;

            j2_reg   <= j1_reg;
            g2_reg   <= g1_reg;
            err2_reg <= err1_reg;
            al2_reg  <= al2_next;

            err3_reg <= err2_reg;
            b3_reg   <= b3_next;
            y3_reg   <= y3_next;

            err4_reg <= err3_reg;
            b4_reg   <= b3_reg;
            y4_reg   <= y3_reg;
            ce4_reg  <= p4[jdc_pkg::C_SHIFT +: 15];

            err5_reg <= err4_reg;
            b5_reg   <= b4_reg;
            c5_reg   <= c5_next;

            err6_reg <= err5_reg;
            rem6_reg <= 9'(b5_reg - d6);
            c6_reg   <= c5_reg;

            err7_reg <= err6_reg;
            rem7_reg <= rem6_reg;
            c7_reg   <= c6_reg;
            e7_reg   <= e7_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== design/julian_day_to_calendar_date_top.sv =====
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_top: Julian day number to calendar date
// Streams Julian day numbers in and month, day of month and signed year out.
// ----------------------------------------------------------------------------
// Each beat on the input carries one Julian day number (day 0 is 1 January
// 4713 BC) and yields exactly one result beat, in order. Days from 2299161
// on are Gregorian dates, earlier ones Julian; years skip zero, so 1 BC is
// -1. A day above 5373484 (31 December 9999) returns range_error with month,
// day_of_month and year all zero. The block keeps no state between beats.
// The result comes from an eight-stage datapath: two stages per constant
// division (reciprocal multiply, then a one-step correction), the
// B/numerator stage, the day-of-year stage, the month lookup and the output
// register. One beat is accepted every cycle; the whole pipeline holds while
// a finished result waits on out_ready, so in_ready follows out_ready
// combinationally once the output register fills.
`default_nettype none

module julian_day_to_calendar_date_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output wire logic                          in_ready,
    input  wire logic [jdc_pkg::DayW-1:0]      day_number,
    output wire logic                          out_valid,
    input  wire logic                          out_ready,
    output wire logic [jdc_pkg::MonthW-1:0]    month,
    output wire logic [jdc_pkg::DomW-1:0]      day_of_month,
    output wire logic [jdc_pkg::YearW-1:0]     year,
    output wire logic                          range_error
);

    jdc_pkg::jdc_res_t res;
    logic              adv;

    // Advance every stage unless a result sits unaccepted at the output
    assign adv      = !res.valid || out_ready;
    assign in_ready = adv;

    jdc_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .day_number (day_number),
        .res        (res)
    );

    assign out_valid    = res.valid;
    assign month        = res.month;
    assign day_of_month = res.day_of_month;
    assign year         = res.year;
    assign range_error  = res.range_error;

    // Out-of-range beats carry an all-zero date
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> (month == '0 && day_of_month == '0 && year == '0))
        else $error("range error beat with nonzero date");

    // Valid dates have month 1..12 and day 1..31
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !range_error) |->
        (month >= 4'd1 && month <= 4'd12 && day_of_month != 5'd0))
        else $error("month or day out of range");

    // No year zero on a valid date
    a_no_year_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !range_error) |-> (year != '0))
        else $error("year zero produced");

    // A stalled result stays valid and keeps its year and month
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(year) && $stable(month)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
